[sv/a1_cell_reference_parser_unit_assert.svh]
// ---------------------------------------------------------------------------
// A1 reference parser assertion macros
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef A1_CELL_REFERENCE_PARSER_UNIT_ASSERT_SVH
`define A1_CELL_REFERENCE_PARSER_UNIT_ASSERT_SVH

// same-cycle implication
`define A1CRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define A1CRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/a1crp_pkg.sv]
// ---------------------------------------------------------------------------
// a1crp_pkg
// Types, widths and codes shared by the A1 cell reference parser.
// ---------------------------------------------------------------------------
package a1crp_pkg;

  localparam int ROW_WIDTH    = 21;
  localparam int COLUMN_WIDTH = 15;
  localparam int ROW_OUT_W    = 20;
  localparam int COL_OUT_W    = 14;
  localparam int ROW_LIMIT_W  = 21;
  localparam int COL_LIMIT_W  = 15;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 21;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COL_LIMIT = 2'd1;

  localparam logic [ROW_LIMIT_W-1:0] ROW_LIMIT_RST = ROW_LIMIT_W'(1 << ROW_OUT_W);
  localparam logic [COL_LIMIT_W-1:0] COL_LIMIT_RST = COL_LIMIT_W'(1 << COL_OUT_W);

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_MALFORMED = 2'd2;
  localparam logic [1:0] ST_BEYOND    = 2'd3;

  typedef struct packed {
    logic [7:0] character;
    logic       no_character;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [ROW_OUT_W-1:0] row_index;
    logic [COL_OUT_W-1:0] column_index;
    logic [1:0]           status;
  } out_item_t;

endpackage

[sv/a1_cell_reference_parser_unit.sv]
// ---------------------------------------------------------------------------
// a1_cell_reference_parser_unit
// Streams an A1 reference one byte per item, gives row, column and status.
// ---------------------------------------------------------------------------
// out_valid rises after the last item's transfer passes the input register
//   and then the result register.
// Throughput: 1 item per cycle while in_stall is low; the parse state loop is registered.
// A 2-entry result buffer keeps input flowing while a result is stalled.
// Synchronous active-low reset clears the parse state and the pipeline;
//   row_limit resets to 1048576 and column_limit to 16384.
module a1_cell_reference_parser_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  a1crp_pkg::in_item_t               in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output a1crp_pkg::out_item_t              out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [a1crp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [a1crp_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import a1crp_pkg::*;

  `include "a1_cell_reference_parser_unit_assert.svh"

  logic [ROW_LIMIT_W-1:0] row_limit_r;
  logic [COL_LIMIT_W-1:0] col_limit_r;
  logic                   in_vld_r;
  in_item_t               in_r;
  logic                   out_vld_r, skid_vld_r;
  out_item_t              out_r, skid_r, out_nxt;
  logic                   adv, res_vld, out_load;
  out_item_t              res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_limit_r <= ROW_LIMIT_RST;
      col_limit_r <= COL_LIMIT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ROW_LIMIT: row_limit_r <= ROW_LIMIT_W'(cfg_data);
        CFG_COL_LIMIT: col_limit_r <= COL_LIMIT_W'(cfg_data);
        default: ;
      endcase
    end
  end

  // input register moves whenever the skid slot is free
  assign in_stall = skid_vld_r;
  assign adv      = in_vld_r & ~skid_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!skid_vld_r) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_vld_r) in_r <= in_data;
  end

  a1crp_scan u_scan (
    .clk          (clk),
    .rst_n        (rst_n),
    .adv          (adv),
    .item         (in_r),
    .row_limit    (row_limit_r),
    .column_limit (col_limit_r),
    .res_vld      (res_vld),
    .res          (res)
  );

  assign out_load = ~out_vld_r | ~out_stall;
  assign out_nxt  = skid_vld_r ? skid_r : res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r  <= skid_vld_r | res_vld;
      skid_vld_r <= 1'b0;
    end else if (res_vld) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_r <= out_nxt;
    if (!out_load && res_vld) skid_r <= res;
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  `A1CRP_ASSERT_NOW(a_skid_behind_out, skid_vld_r, out_vld_r, "skid full with output empty")
  `A1CRP_ASSERT_NEXT(a_skid_drains, skid_vld_r && !out_stall, !skid_vld_r, "skid not drained")
  `A1CRP_ASSERT_NEXT(a_skid_catches, in_vld_r && in_r.last && !skid_vld_r && out_vld_r && out_stall, skid_vld_r, "stalled result lost")
  `A1CRP_ASSERT_NOW(a_idx_zero, out_vld_r && (out_r.status != ST_OK), (out_r.row_index == '0) && (out_r.column_index == '0), "index set on error status")

endmodule

[sv/a1crp_scan.sv]
// ---------------------------------------------------------------------------
// a1crp_scan
// Parse state per character and the closing result on the last item.
// ---------------------------------------------------------------------------
module a1crp_scan (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               adv,
  input  a1crp_pkg::in_item_t                item,
  input  logic [a1crp_pkg::ROW_LIMIT_W-1:0]  row_limit,
  input  logic [a1crp_pkg::COL_LIMIT_W-1:0]  column_limit,
  output logic                               res_vld,
  output a1crp_pkg::out_item_t               res
);
  import a1crp_pkg::*;

  localparam logic [1:0] PH_START   = 2'd0;
  localparam logic [1:0] PH_LETTERS = 2'd1;
  localparam logic [1:0] PH_DIGITS  = 2'd2;

  localparam int COL_NXT_W = COLUMN_WIDTH + 5;
  localparam int ROW_NXT_W = ROW_WIDTH + 4;
  localparam int CMP_W     = 33;

  localparam logic [7:0] CHAR_A = 8'h41;
  localparam logic [7:0] CHAR_Z = 8'h5A;
  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;

  localparam logic [COL_NXT_W-1:0] COL_RADIX = COL_NXT_W'(26);
  localparam logic [ROW_NXT_W-1:0] ROW_RADIX = ROW_NXT_W'(10);

  logic [1:0]              phase_r, phase_nxt;
  logic [COLUMN_WIDTH-1:0] col_acc_r, col_acc_nxt;
  logic [ROW_WIDTH-1:0]    row_acc_r, row_acc_nxt;
  logic                    col_big_r, col_big_nxt;
  logic                    row_big_r, row_big_nxt;
  logic                    mal_r, mal_nxt;

  logic                    letter, digit;
  logic [7:0]              ltr_val, dig_val;
  logic [COL_NXT_W-1:0]    col_sum;
  logic [ROW_NXT_W-1:0]    row_sum;
  logic                    col_sat, row_sat;
  logic [ROW_LIMIT_W-1:0]  rlim;
  logic [COL_LIMIT_W-1:0]  clim;
  logic                    row_over, col_over;
  logic [1:0]              status;

  // multiply-add for both accumulators, saturating above the register width
  always_comb begin
    letter  = item.character inside {[CHAR_A:CHAR_Z]};
    digit   = item.character inside {[CHAR_0:CHAR_9]};
    ltr_val = item.character - CHAR_A + 8'd1;
    dig_val = item.character - CHAR_0;
    col_sum = COL_NXT_W'(col_acc_r) * COL_RADIX + COL_NXT_W'(ltr_val);
    row_sum = ROW_NXT_W'(row_acc_r) * ROW_RADIX + ROW_NXT_W'(dig_val);
    col_sat = |col_sum[COL_NXT_W-1:COLUMN_WIDTH];
    row_sat = |row_sum[ROW_NXT_W-1:ROW_WIDTH];
  end

  always_comb begin
    phase_nxt   = phase_r;
    col_acc_nxt = col_acc_r;
    row_acc_nxt = row_acc_r;
    col_big_nxt = col_big_r;
    row_big_nxt = row_big_r;
    mal_nxt     = mal_r;
    if (!item.no_character) begin
      case (phase_r)
        PH_START: begin
          if (letter) begin
            col_acc_nxt = col_sat ? '1 : col_sum[COLUMN_WIDTH-1:0];
            col_big_nxt = col_big_r | col_sat;
          end else begin
            mal_nxt = 1'b1;
          end
          phase_nxt = PH_LETTERS;
        end
        PH_LETTERS: begin
          if (letter) begin
            col_acc_nxt = col_sat ? '1 : col_sum[COLUMN_WIDTH-1:0];
            col_big_nxt = col_big_r | col_sat;
          end else if (digit) begin
            // a leading zero is malformed but still counts as a digit
            if (item.character == CHAR_0) mal_nxt = 1'b1;
            row_acc_nxt = row_sat ? '1 : row_sum[ROW_WIDTH-1:0];
            row_big_nxt = row_big_r | row_sat;
            phase_nxt   = PH_DIGITS;
          end else begin
            mal_nxt = 1'b1;
          end
        end
        default: begin
          if (digit) begin
            row_acc_nxt = row_sat ? '1 : row_sum[ROW_WIDTH-1:0];
            row_big_nxt = row_big_r | row_sat;
          end else begin
            mal_nxt = 1'b1;
          end
        end
      endcase
    end
  end

  // closing result, taken from the state after this item
  always_comb begin
    rlim     = (row_limit > ROW_LIMIT_RST) ? ROW_LIMIT_RST : row_limit;
    clim     = (column_limit > COL_LIMIT_RST) ? COL_LIMIT_RST : column_limit;
    row_over = CMP_W'(row_acc_nxt) > CMP_W'(rlim);
    col_over = CMP_W'(col_acc_nxt) > CMP_W'(clim);
    if (phase_nxt == PH_START) begin
      status = ST_EMPTY;
    end else if (mal_nxt || (phase_nxt != PH_DIGITS)) begin
      status = ST_MALFORMED;
    end else if (row_big_nxt || col_big_nxt || row_over || col_over ||
                 (row_acc_nxt == '0) || (col_acc_nxt == '0)) begin
      status = ST_BEYOND;
    end else begin
      status = ST_OK;
    end
    res.status       = status;
    res.row_index    = (status == ST_OK) ? ROW_OUT_W'(row_acc_nxt - 1'b1) : '0;
    res.column_index = (status == ST_OK) ? COL_OUT_W'(col_acc_nxt - 1'b1) : '0;
    res_vld          = adv & item.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (adv && item.last)) begin
      phase_r   <= PH_START;
      col_acc_r <= '0;
      row_acc_r <= '0;
      col_big_r <= 1'b0;
      row_big_r <= 1'b0;
      mal_r     <= 1'b0;
    end else if (adv) begin
      phase_r   <= phase_nxt;
      col_acc_r <= col_acc_nxt;
      row_acc_r <= row_acc_nxt;
      col_big_r <= col_big_nxt;
      row_big_r <= row_big_nxt;
      mal_r     <= mal_nxt;
    end
  end

endmodule
